// File: rtl/kfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfc_pkg
// Shared constants and types of the key frequency counter.
// ----------------------------------------------------------------------------
package kfc_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int USED_W   = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // one table entry: key in the low half, count in the high half
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] key;
    } kfc_entry_t;

    // memory request from the controller to the table
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        kfc_entry_t       wr_data;
    } kfc_mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_DUMP_READ,
        ST_DUMP_LOAD,
        ST_DUMP_SEND
    } kfc_state_t;

endpackage : kfc_pkg
`default_nettype wire

// File: rtl/kfc_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfc_table
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kfc_table (
    input  wire logic                  clk,
    input  wire kfc_pkg::kfc_mem_req_t req,
    output kfc_pkg::kfc_entry_t        rd_data
);
    import kfc_pkg::*;

    kfc_entry_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule : kfc_table
`default_nettype wire

// File: rtl/kfc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfc_ctrl
// Sequencer: linear scan, read-modify-write of counts, insertion and dump.
// ----------------------------------------------------------------------------
module kfc_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [kfc_pkg::KEY_W-1:0]  in_key,
    input  wire logic                       in_last,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [kfc_pkg::KEY_W-1:0]       out_key,
    output logic [kfc_pkg::CNT_W-1:0]       out_count,
    output logic                            out_drop,
    output logic                            out_last,
    output kfc_pkg::kfc_mem_req_t           mem_req,
    input  wire kfc_pkg::kfc_entry_t        mem_rd_data
);
    import kfc_pkg::*;

    kfc_state_t        state_reg, state_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              last_reg, last_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]  dump_idx_reg, dump_idx_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic              ovf_reg, ovf_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic              out_drop_reg, out_drop_next;
    logic              out_last_reg, out_last_next;

    logic match;
    logic scan_last;
    logic dump_last;
    logic table_full;
    logic [CNT_W-1:0] count_inc;

    assign match      = (mem_rd_data.key == key_reg);
    assign scan_last  = ((USED_W'(scan_idx_reg) + USED_W'(1)) == used_reg);
    assign dump_last  = ((USED_W'(dump_idx_reg) + USED_W'(1)) == used_reg);
    assign table_full = (used_reg >= USED_W'(CAPACITY));
    assign count_inc  = (mem_rd_data.count == COUNT_MAX) ? COUNT_MAX
                                                         : mem_rd_data.count + CNT_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (used_reg == '0) ? ST_INSERT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = last_reg ? ST_DUMP_READ : ST_IDLE;
                end
                else if (scan_last)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                state_next = last_reg ? ST_DUMP_READ : ST_IDLE;
            end
            ST_DUMP_READ:
            begin
                state_next = ST_DUMP_LOAD;
            end
            ST_DUMP_LOAD:
            begin
                state_next = ST_DUMP_SEND;
            end
            ST_DUMP_SEND:
            begin
                if (out_ready)
                begin
                    state_next = out_last_reg ? ST_IDLE : ST_DUMP_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and memory requests
    always_comb
    begin
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        mem_req         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    mem_req.wr_en         = 1'b1;
                    mem_req.wr_addr       = scan_idx_reg;
                    mem_req.wr_data.key   = key_reg;
                    mem_req.wr_data.count = count_inc;
                end
                else if (!scan_last)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_INSERT:
            begin
                if (!table_full)
                begin
                    mem_req.wr_en         = 1'b1;
                    mem_req.wr_addr       = used_reg[IDX_W-1:0];
                    mem_req.wr_data.key   = key_reg;
                    mem_req.wr_data.count = CNT_W'(1);
                end
            end
            ST_DUMP_READ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = dump_idx_reg;
            end
            ST_DUMP_LOAD:
            begin
                mem_req = '0;
            end
            ST_DUMP_SEND:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        key_next       = key_reg;
        last_next      = last_reg;
        scan_idx_next  = scan_idx_reg;
        dump_idx_next  = dump_idx_reg;
        used_next      = used_reg;
        ovf_next       = ovf_reg;
        out_key_next   = out_key_reg;
        out_count_next = out_count_reg;
        out_drop_next  = out_drop_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next      = in_key;
                    last_next     = in_last;
                    scan_idx_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (!match && !scan_last)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_INSERT:
            begin
                if (table_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    used_next = used_reg + USED_W'(1);
                end
            end
            ST_DUMP_LOAD:
            begin
                out_key_next   = mem_rd_data.key;
                out_count_next = mem_rd_data.count;
                out_drop_next  = ovf_reg;
                out_last_next  = dump_last;
            end
            ST_DUMP_SEND:
            begin
                if (out_ready)
                begin
                    if (out_last_reg)
                    begin
                        used_next     = '0;
                        ovf_next      = 1'b0;
                        dump_idx_next = '0;
                    end
                    else
                    begin
                        dump_idx_next = dump_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            dump_idx_reg <= '0;
            used_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            dump_idx_reg <= dump_idx_next;
            used_reg     <= used_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        last_reg      <= last_next;
        out_key_reg   <= out_key_next;
        out_count_reg <= out_count_next;
        out_drop_reg  <= out_drop_next;
        out_last_reg  <= out_last_next;
    end

    assign out_key   = out_key_reg;
    assign out_count = out_count_reg;
    assign out_drop  = out_drop_reg;
    assign out_last  = out_last_reg;

endmodule : kfc_ctrl
`default_nettype wire

// File: rtl/key_frequency_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_frequency_counter
// Histogram of signed 32-bit keys with first-insertion-order dump.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one key per transfer on s_tdata; s_tlast marks the last
//   key of a set. Master channel: one transfer per table entry, key and
//   count on m_tdata, dropped-key mark on m_tuser, m_tlast on the final one.
// Throughput: one key at a time. A key is accepted in the idle state, then
//   the scan reads one entry per cycle from the single read port of the
//   entry table, over the N entries used so far (up to 64). A hit writes
//   the bumped count in the cycle that finds it and ends the scan early; a
//   miss goes on to an insert state that writes the new entry.
// Dump: after the last key is counted, each entry is read, loaded into the
//   output register, then presented until m_tready accepts it.
//   s_tready stays low for the whole dump; a stalled receiver simply holds
//   the current entry on the master side.
// Reset: rst_n clears the fill count, the overflow mark and the sequencer.
//   Table contents are not cleared; only entries below the fill count are
//   ever read, so no clearing pass is needed. After a dump the table is
//   empty again.
// ----------------------------------------------------------------------------
module key_frequency_counter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] key
    input  wire logic        s_tlast,   // end_of_set
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] entry_key, [63:32] entry_count
    output logic             m_tuser,   // dropped_keys
    output logic             m_tlast    // last_entry
);
    import kfc_pkg::*;

    kfc_mem_req_t     mem_req;
    kfc_entry_t       mem_rd_data;
    logic [KEY_W-1:0] out_key;
    logic [CNT_W-1:0] out_count;

    // sequencer and datapath
    kfc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_key      (s_tdata),
        .in_last     (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_key     (out_key),
        .out_count   (out_count),
        .out_drop    (m_tuser),
        .out_last    (m_tlast),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    // entry table, registered read data
    kfc_table u_table (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign m_tdata = {out_count, out_key};

    // input is never taken while a dump entry is on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
    else $error("input ready during dump");

    // one key at a time: after a transfer in, the block is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("second key taken back to back");

    // the final entry ends the dump
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("dump did not end after last entry");

    // a dump only begins after a key marked end of set
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tlast) |=> !m_tvalid)
    else $error("dump without end of set");

endmodule : key_frequency_counter
`default_nettype wire
